/* hdl/cmtm_pkg.sv */
// shared types and constants for the can message timeout monitor
package cmtm_pkg;

    // number of supervised entries and widths fixed by the table layout
    localparam int NODES_DEF  = 4;
    localparam int MASK_W     = 4;
    localparam int ID_W       = 11;
    localparam int MS_W       = 16;
    localparam int TIME_W     = 17;
    localparam int RCNT_W     = 7;
    localparam int CHAN_W     = 3;
    localparam int ELAPSED_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ID_TBL_W   = 44;

    // reception count limits
    localparam logic [RCNT_W-1:0] RCNT_MAX     = 7'd100;
    localparam logic [RCNT_W-1:0] RCNT_RECOVER = 7'd5;

    // two fifths of the recover time: multiply by 2^18/5 rounded up, then shift
    localparam logic [16:0] RECIP_5     = 17'd52429;
    localparam int          RECIP_SHIFT = 18;

    // register reset values
    localparam logic [CHAN_W-1:0]   CHANNEL_RST = 3'd0;
    localparam logic [2:0]          ACTIVE_RST  = 3'd1;
    localparam logic [ID_TBL_W-1:0] ID_TBL_RST  = 44'h310;
    localparam logic [63:0]         TMO_TBL_RST = 64'd1050;
    localparam logic [63:0]         REC_TBL_RST = 64'd500;
    localparam logic [MS_W-1:0]     DELAY_RST   = 16'd1000;

    // item opcodes
    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_TICK  = 2'd1,
        OP_RESET = 2'd2,
        OP_NONE  = 2'd3
    } cmtm_op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL = 3'd0,
        CFG_ACTIVE  = 3'd1,
        CFG_ID_TBL  = 3'd2,
        CFG_TMO_TBL = 3'd3,
        CFG_REC_TBL = 3'd4,
        CFG_DELAY   = 3'd5
    } cmtm_cfg_t;

    // word handed from cell to cell along the chain
    typedef struct packed {
        logic                 frame;
        logic                 init;
        logic                 proc;
        logic [ID_W-1:0]      fid;
        logic [ELAPSED_W-1:0] elapsed;
        logic [MASK_W-1:0]    dis;
        logic [MASK_W-1:0]    set_m;
        logic [MASK_W-1:0]    clr_m;
        logic [MASK_W-1:0]    miss_m;
    } cmtm_word_t;

endpackage

/* hdl/can_message_timeout_monitor.sv */
// top level: configuration registers, decoder and the chain of entry cells
// path: the decoder registers the accepted item, then each cell registers the word; done is the last cell's valid
// one item at a time until the last cell: busy drops while done is shown,
// so the next start is taken in that cycle; the word walks one cell per cycle
// reset: rst_n clears all entries, flags and counters and loads register defaults
// the result is shown for exactly one cycle; the receiver cannot stall it
module can_message_timeout_monitor
#(
    parameter int NODES = cmtm_pkg::NODES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      opcode,
    input  logic [cmtm_pkg::CHAN_W-1:0]     channel,
    input  logic [cmtm_pkg::ID_W-1:0]       frame_id,
    input  logic [cmtm_pkg::ELAPSED_W-1:0]  elapsed_ms,
    input  logic                            ignition_on,
    input  logic                            fault_enable,
    input  logic [cmtm_pkg::MASK_W-1:0]     disable_mask,
    input  logic                            cfg_we,
    input  logic [cmtm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cmtm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic [cmtm_pkg::MASK_W-1:0]     missing_mask,
    output logic [cmtm_pkg::MASK_W-1:0]     fault_set_mask,
    output logic [cmtm_pkg::MASK_W-1:0]     fault_clear_mask
);
    import cmtm_pkg::*;

    logic [CHAN_W-1:0]   channel_reg;
    logic [2:0]          active_reg;
    logic [ID_TBL_W-1:0] id_tbl_reg;
    logic [63:0]         tmo_tbl_reg;
    logic [63:0]         rec_tbl_reg;
    logic [MS_W-1:0]     delay_reg;

    logic                accept;
    logic [2:0]          n_used;
    logic [MASK_W-1:0]   all_mask;
    logic [NODES-1:0]    active_vec;
    logic                chain_valid [0:NODES];
    cmtm_word_t          chain_word  [0:NODES];
    logic [NODES-1:0]    cell_valid;
    logic [NODES-1:0]    last_bit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= CHANNEL_RST;
            active_reg  <= ACTIVE_RST;
            id_tbl_reg  <= ID_TBL_RST;
            tmo_tbl_reg <= TMO_TBL_RST;
            rec_tbl_reg <= REC_TBL_RST;
            delay_reg   <= DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cmtm_cfg_t'(cfg_index))
                CFG_CHANNEL: channel_reg <= cfg_data[CHAN_W-1:0];
                CFG_ACTIVE:  active_reg  <= cfg_data[2:0];
                CFG_ID_TBL:  id_tbl_reg  <= cfg_data[ID_TBL_W-1:0];
                CFG_TMO_TBL: tmo_tbl_reg <= cfg_data;
                CFG_REC_TBL: rec_tbl_reg <= cfg_data;
                CFG_DELAY:   delay_reg   <= cfg_data[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // entries in use, capped at the number of cells
    assign n_used = (active_reg > 3'(NODES)) ? 3'(NODES) : active_reg;

    always_comb
    begin
        all_mask   = '0;
        active_vec = '0;
        for (int i = 0; i < NODES; i++)
        begin
            active_vec[i] = (3'(i) < n_used);
            all_mask[i]   = active_vec[i];
        end
    end

    assign accept = start && !busy;

    // decoder and global state
    cmtm_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .opcode        (opcode),
        .channel       (channel),
        .frame_id      (frame_id),
        .elapsed_ms    (elapsed_ms),
        .ignition_on   (ignition_on),
        .fault_enable  (fault_enable),
        .disable_mask  (disable_mask),
        .mon_channel   (channel_reg),
        .startup_delay (delay_reg),
        .all_mask      (all_mask),
        .word_valid    (chain_valid[0]),
        .word          (chain_word[0])
    );

    // chain of entry cells
    for (genvar g = 0; g < NODES; g++)
    begin : g_cell
        cmtm_cell #(.IDX(g)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .active    (active_vec[g]),
            .entry_id  (id_tbl_reg[ID_W*g +: ID_W]),
            .timeout   (tmo_tbl_reg[MS_W*g +: MS_W]),
            .recover   (rec_tbl_reg[MS_W*g +: MS_W]),
            .in_valid  (chain_valid[g]),
            .in_word   (chain_word[g]),
            .out_valid (chain_valid[g+1]),
            .out_word  (chain_word[g+1])
        );
        assign cell_valid[g] = chain_valid[g+1];
    end

    // busy while a word is in flight ahead of the last cell
    assign last_bit = NODES'(1) << (NODES - 1);
    assign busy     = chain_valid[0] || |(cell_valid & ~last_bit);

    // result from the last cell
    assign done             = chain_valid[NODES];
    assign missing_mask     = chain_word[NODES].miss_m;
    assign fault_set_mask   = chain_word[NODES].set_m;
    assign fault_clear_mask = chain_word[NODES].clr_m;

endmodule

/* hdl/cmtm_ctrl.sv */
// item decoder with reset, startup hold and ignition state; launches the chain word
module cmtm_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [1:0]                    opcode,
    input  logic [cmtm_pkg::CHAN_W-1:0]   channel,
    input  logic [cmtm_pkg::ID_W-1:0]     frame_id,
    input  logic [cmtm_pkg::ELAPSED_W-1:0] elapsed_ms,
    input  logic                          ignition_on,
    input  logic                          fault_enable,
    input  logic [cmtm_pkg::MASK_W-1:0]   disable_mask,
    input  logic [cmtm_pkg::CHAN_W-1:0]   mon_channel,
    input  logic [cmtm_pkg::MS_W-1:0]     startup_delay,
    input  logic [cmtm_pkg::MASK_W-1:0]   all_mask,
    output logic                          word_valid,
    output cmtm_pkg::cmtm_word_t          word
);
    import cmtm_pkg::*;

    logic               pend_reg, pend_next;
    logic               started_reg, started_next;
    logic [TIME_W-1:0]  timer_reg, timer_next;
    logic               valid_reg;
    cmtm_word_t         word_reg, word_next;

    // decode one item into global decisions and the chain word
    always_comb
    begin
        logic              go;
        logic [TIME_W-1:0] sum;
        pend_next    = pend_reg;
        started_next = started_reg;
        timer_next   = timer_reg;
        go           = 1'b1;
        sum          = timer_reg + TIME_W'(elapsed_ms);
        word_next         = '0;
        word_next.fid     = frame_id;
        word_next.elapsed = elapsed_ms;
        word_next.dis     = disable_mask;
        unique case (cmtm_op_t'(opcode))
            OP_FRAME:
            begin
                word_next.frame = (channel == mon_channel);
            end
            OP_RESET:
            begin
                pend_next = 1'b1;
            end
            OP_TICK:
            begin
                // a pending reset initialises first
                if (pend_reg)
                begin
                    pend_next      = 1'b0;
                    word_next.init = 1'b1;
                end
                // startup hold after ignition on
                if (ignition_on && !started_reg)
                begin
                    if (sum <= TIME_W'(startup_delay))
                    begin
                        timer_next      = sum;
                        word_next.clr_m = all_mask;
                        go              = 1'b0;
                    end
                    else
                    begin
                        timer_next     = '0;
                        started_next   = 1'b1;
                        word_next.init = 1'b1;
                    end
                end
                // ignition off stops supervision, resets the startup hold and, once started, clears all faults
                if (go && !ignition_on)
                begin
                    if (started_reg)
                    begin
                        word_next.clr_m = all_mask;
                    end
                    timer_next   = '0;
                    started_next = 1'b0;
                    go           = 1'b0;
                end
                word_next.proc = go && fault_enable;
            end
            OP_NONE:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b0;
            started_reg <= 1'b0;
            timer_reg   <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
            if (accept)
            begin
                pend_reg    <= pend_next;
                started_reg <= started_next;
                timer_reg   <= timer_next;
            end
        end
    end

    // word payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

/* hdl/cmtm_cell.sv */
// one supervised entry: time, reception count and missing flag, one chain stage
module cmtm_cell
#(
    parameter int IDX = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      active,
    input  logic [cmtm_pkg::ID_W-1:0] entry_id,
    input  logic [cmtm_pkg::MS_W-1:0] timeout,
    input  logic [cmtm_pkg::MS_W-1:0] recover,
    input  logic                      in_valid,
    input  cmtm_pkg::cmtm_word_t      in_word,
    output logic                      out_valid,
    output cmtm_pkg::cmtm_word_t      out_word
);
    import cmtm_pkg::*;

    logic [TIME_W-1:0] time_reg, time_next;
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next;
    logic              miss_reg, miss_next;
    logic              valid_reg;
    cmtm_word_t        word_reg, word_next;
    logic [33:0]       prod;
    logic [MS_W-1:0]   thr;

    // two fifths of the recover time
    assign prod = {recover, 1'b0} * RECIP_5;
    assign thr  = prod[RECIP_SHIFT +: MS_W];

    // entry update for the arriving word
    always_comb
    begin
        logic [TIME_W-1:0] t;
        logic [RCNT_W-1:0] r;
        logic              m;
        logic              set_b;
        logic              clr_b;
        t     = time_reg;
        r     = rcnt_reg;
        m     = miss_reg;
        set_b = 1'b0;
        clr_b = 1'b0;
        if (in_word.frame)
        begin
            if (in_word.fid == entry_id)
            begin
                t = '0;
                if (r < RCNT_MAX)
                begin
                    r = r + 1'b1;
                end
            end
        end
        else
        begin
            if (in_word.init)
            begin
                m = 1'b1;
                t = '0;
                r = RCNT_RECOVER;
            end
            if (in_word.proc)
            begin
                if (in_word.dis[IDX])
                begin
                    t = '0;
                    r = RCNT_MAX;
                end
                if (t >= TIME_W'(timeout))
                begin
                    r = '0;
                    if (!m)
                    begin
                        m     = 1'b1;
                        set_b = 1'b1;
                    end
                end
                else
                begin
                    t = t + TIME_W'(in_word.elapsed);
                    if (t >= TIME_W'(thr))
                    begin
                        r = '0;
                    end
                    if (r >= RCNT_RECOVER && m)
                    begin
                        m     = 1'b0;
                        clr_b = 1'b1;
                    end
                end
            end
        end
        time_next = t;
        rcnt_next = r;
        miss_next = m;
        word_next = in_word;
        if (active)
        begin
            word_next.set_m[IDX]  = in_word.set_m[IDX] | set_b;
            word_next.clr_m[IDX]  = in_word.clr_m[IDX] | clr_b;
            word_next.miss_m[IDX] = m;
        end
    end

    // entry state, touched only while the entry is in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            rcnt_reg  <= '0;
            miss_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            if (in_valid && active)
            begin
                time_reg <= time_next;
                rcnt_reg <= rcnt_next;
                miss_reg <= miss_next;
            end
        end
    end

    // hand the word to the next cell
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* hdl/cmtm_checker.sv */
// port-level checks for the can message timeout monitor, bound to the top level
module cmtm_checker
#(
    parameter int NODES = cmtm_pkg::NODES_DEF
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [cmtm_pkg::MASK_W-1:0] missing_mask,
    input logic [cmtm_pkg::MASK_W-1:0] fault_set_mask,
    input logic [cmtm_pkg::MASK_W-1:0] fault_clear_mask
);
    import cmtm_pkg::*;

    // an accepted word makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // every accepted word gives a result after the chain
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(NODES+1) done)
        else $error("result missing after accept");

    // a fault is never raised and cleared by the same word
    a_set_clear_apart: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((fault_set_mask & fault_clear_mask) == '0))
        else $error("fault raised and cleared together");

    // a raised fault shows as missing
    a_set_is_missing: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((fault_set_mask & ~missing_mask) == '0))
        else $error("raised fault not marked missing");

endmodule

bind can_message_timeout_monitor cmtm_checker #(.NODES(NODES)) u_cmtm_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .missing_mask     (missing_mask),
    .fault_set_mask   (fault_set_mask),
    .fault_clear_mask (fault_clear_mask)
);
